@@ hdl/ffea_pkg.sv @@
// Package: shared types and constants for the first-fit extent allocator.
`timescale 1ns / 1ps

package ffea_pkg;

  localparam int MAX_EXTENTS_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 32;
  localparam int ID_W   = 16;
  localparam int STAT_W = 2;
  localparam int EIDX_W = $clog2(MAX_EXTENTS_DEF + 1);
  // a + size can reach 3*2^32 - 2; the running address a stays within 33 bits
  localparam int SUM_W  = 34;
  localparam int A_W    = 33;

  localparam logic [CMD_W-1:0] CMD_FIND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] req_size;
    logic [ID_W-1:0]   file_id;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] found_addr;
    logic [EIDX_W-1:0] error_index;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [ID_W-1:0]   id;
  } extent_t;

  // shared adder request: sum = opa + opb + cin, lt = sum < limit
  typedef struct packed {
    logic [SUM_W-1:0] opa;
    logic [SUM_W-1:0] opb;
    logic             cin;
    logic [SUM_W-1:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             lt;
  } alu_rsp_t;

endpackage

@@ hdl/first_fit_extent_allocator.sv @@
// Top level of the first-fit extent allocator: config register, sequencer and shared adder.
`timescale 1ns / 1ps

// Find free walks the table entry by entry; allocate moves entries up from the top to open
//   a slot; release searches by id, then shifts later entries down; check compares pairs.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// The pace is set by the single read port of the extent table and the one shared adder.
// Result is shown for one cycle on out_valid; the receiver cannot stall it.
// Reset (rst_n low, synchronous) empties the table and clears disk_size to 0.
module first_fit_extent_allocator #(
  parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command transaction: taken when start is high and busy is low
  input  logic                        start,
  input  ffea_pkg::in_t               in_data,
  output logic                        busy,
  // result transaction: one cycle, marked by out_valid
  output logic                        out_valid,
  output ffea_pkg::out_t              out_data,
  // disk size register: the user must write it only while idle; the block does not enforce it
  input  logic                        cfg_we,
  input  logic [ffea_pkg::ADDR_W-1:0] cfg_wdata
);

  logic [ffea_pkg::ADDR_W-1:0] disk_size_r;
  ffea_pkg::alu_req_t          alu_req;
  ffea_pkg::alu_rsp_t          alu_rsp;

  // disk size: an extent must end strictly below it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r <= '0;
    end else if (cfg_we) begin
      disk_size_r <= cfg_wdata;
    end
  end

  // sequencer holds the table, the counters and the result register
  ffea_ctrl #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .disk_size (disk_size_r),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one adder/compare shared by the find-free, allocate and check steps
  ffea_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

@@ hdl/ffea_alu.sv @@
// Shared adder with limit compare, used by the find-free, allocate and check commands.
`timescale 1ns / 1ps

module ffea_alu (
  input  ffea_pkg::alu_req_t req,
  output ffea_pkg::alu_rsp_t rsp
);

  logic [ffea_pkg::SUM_W-1:0] sum;

  assign sum     = req.opa + req.opb + ffea_pkg::SUM_W'(req.cin);
  assign rsp.sum = sum;
  assign rsp.lt  = (sum < req.limit);

endmodule

@@ hdl/ffea_ctrl.sv @@
// Sequencer and extent table: walks the table one entry per step for each command.
`timescale 1ns / 1ps

module ffea_ctrl #(
  parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ffea_pkg::in_t               in_data,
  input  logic [ffea_pkg::ADDR_W-1:0] disk_size,
  output ffea_pkg::alu_req_t          alu_req,
  input  ffea_pkg::alu_rsp_t          alu_rsp,
  output logic                        busy,
  output logic                        out_valid,
  output ffea_pkg::out_t              out_data
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SW = ffea_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FF_SUM,
    S_FF_CMP,
    S_AL_CHK,
    S_AL_RD,
    S_AL_CMP,
    S_RL_RD,
    S_RL_CMP,
    S_SD_RD,
    S_SD_WR,
    S_CK_RD,
    S_CK_SUM,
    S_CK_CMP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                k_r, k_nxt, n_r, n_nxt;
  logic [ffea_pkg::A_W-1:0]     a_r, a_nxt;
  logic [SW-1:0]                sum_r, sum_nxt;
  logic                         sumlt_r, sumlt_nxt;
  ffea_pkg::in_t                req_r, req_nxt;
  ffea_pkg::out_t               out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // table memory: one write port, one registered read port
  ffea_pkg::extent_t            mem [MAX_EXTENTS];
  ffea_pkg::extent_t            rdata_r, wdata, new_ext;
  logic [AW-1:0]                raddr, waddr;
  logic                         we;

  logic [CW:0]                  k_p1, k_p2, n_w;
  logic [CW-1:0]                k_m1;
  logic [31:0]                  k32, n32;

  assign k_p1 = {1'b0, k_r} + (CW+1)'(1);
  assign k_p2 = {1'b0, k_r} + (CW+1)'(2);
  assign n_w  = {1'b0, n_r};
  assign k_m1 = k_r - CW'(1);
  assign k32  = 32'(k_r);
  assign n32  = 32'(n_r);

  assign new_ext.start = req_r.start_addr;
  assign new_ext.size  = req_r.req_size;
  assign new_ext.id    = req_r.file_id;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    sum_nxt       = sum_r;
    sumlt_nxt     = sumlt_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    raddr         = k_r[AW-1:0];
    waddr         = k_r[AW-1:0];
    wdata         = rdata_r;
    we            = 1'b0;
    alu_req.opa   = SW'(rdata_r.start);
    alu_req.opb   = SW'(rdata_r.size);
    alu_req.cin   = 1'b0;
    alu_req.limit = SW'(disk_size);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          k_nxt   = '0;
          a_nxt   = ffea_pkg::A_W'(1);
          case (in_data.command)
            ffea_pkg::CMD_FIND:    state_nxt = S_FF_SUM;
            ffea_pkg::CMD_ALLOC:   state_nxt = S_AL_CHK;
            ffea_pkg::CMD_RELEASE: state_nxt = S_RL_RD;
            default:               state_nxt = S_CK_RD;
          endcase
        end
      end

      // find free: form a + want and fetch entry k
      S_FF_SUM: begin
        alu_req.opa = SW'(a_r);
        alu_req.opb = SW'(req_r.req_size);
        sum_nxt     = alu_rsp.sum;
        sumlt_nxt   = alu_rsp.lt;
        state_nxt   = S_FF_CMP;
      end

      S_FF_CMP: begin
        // adder: end of entry k plus one, the next candidate
        alu_req.cin = 1'b1;
        if (!sumlt_r) begin
          out_nxt       = '{status: ffea_pkg::ST_NO_SPACE, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (k_r >= n_r || sum_r < SW'(rdata_r.start)) begin
          out_nxt = '{status: ffea_pkg::ST_OK, found_addr: a_r[ffea_pkg::ADDR_W-1:0],
                      error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (a_r < ffea_pkg::A_W'(rdata_r.start)) begin
            a_nxt = alu_rsp.sum[ffea_pkg::A_W-1:0];
          end
          k_nxt     = k_p1[CW-1:0];
          state_nxt = S_FF_SUM;
        end
      end

      // allocate: capacity and disk end, then insertion walking down from the top
      S_AL_CHK: begin
        alu_req.opa = SW'(req_r.start_addr);
        alu_req.opb = SW'(req_r.req_size);
        if (n_w >= (CW+1)'(MAX_EXTENTS)) begin
          out_nxt       = '{status: ffea_pkg::ST_FULL, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!alu_rsp.lt) begin
          out_nxt       = '{status: ffea_pkg::ST_NO_SPACE, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt     = n_r;
          state_nxt = S_AL_RD;
        end
      end

      S_AL_RD: begin
        raddr = k_m1[AW-1:0];
        if (k_r == '0) begin
          we            = 1'b1;
          wdata         = new_ext;
          n_nxt         = n_r + CW'(1);
          out_nxt       = '{status: ffea_pkg::ST_OK, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_AL_CMP;
        end
      end

      S_AL_CMP: begin
        we = 1'b1;
        if (rdata_r.start > req_r.start_addr) begin
          k_nxt     = k_m1;
          state_nxt = S_AL_RD;
        end else begin
          wdata         = new_ext;
          n_nxt         = n_r + CW'(1);
          out_nxt       = '{status: ffea_pkg::ST_OK, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // release: search by id, then close the gap
      S_RL_RD: begin
        if (k_r >= n_r) begin
          out_nxt       = '{status: ffea_pkg::ST_NOT_FOUND, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RL_CMP;
        end
      end

      S_RL_CMP: begin
        k_nxt = k_p1[CW-1:0];
        if (rdata_r.id == req_r.file_id) begin
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_RL_RD;
        end
      end

      S_SD_RD: begin
        if (k_r >= n_r) begin
          n_nxt         = n_r - CW'(1);
          out_nxt       = '{status: ffea_pkg::ST_OK, found_addr: '0, error_index: '0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SD_WR;
        end
      end

      S_SD_WR: begin
        we        = 1'b1;
        waddr     = k_m1[AW-1:0];
        k_nxt     = k_p1[CW-1:0];
        state_nxt = S_SD_RD;
      end

      // check: end of entry k against start of entry k+1
      S_CK_RD: begin
        raddr = '0;
        if (n_r < CW'(2)) begin
          out_nxt = '{status: ffea_pkg::ST_OK, found_addr: '0,
                      error_index: n32[ffea_pkg::EIDX_W-1:0]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CK_SUM;
        end
      end

      S_CK_SUM: begin
        raddr     = k_p1[AW-1:0];
        sum_nxt   = alu_rsp.sum;
        state_nxt = S_CK_CMP;
      end

      S_CK_CMP: begin
        raddr = k_p2[AW-1:0];
        if (sum_r >= SW'(rdata_r.start)) begin
          out_nxt = '{status: ffea_pkg::ST_OK, found_addr: '0,
                      error_index: k32[ffea_pkg::EIDX_W-1:0]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (k_p2 >= n_w) begin
          out_nxt = '{status: ffea_pkg::ST_OK, found_addr: '0,
                      error_index: n32[ffea_pkg::EIDX_W-1:0]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          sum_nxt = alu_rsp.sum;
          k_nxt   = k_p1[CW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r     <= a_nxt;
    sum_r   <= sum_nxt;
    sumlt_r <= sumlt_nxt;
    req_r   <= req_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ bench/first_fit_extent_allocator_tb.sv @@
// Self-checking testbench for the first-fit extent allocator: directed and random commands.
`timescale 1ns / 1ps

module first_fit_extent_allocator_tb;

  localparam int DEPTH  = ffea_pkg::MAX_EXTENTS_DEF;
  localparam int CMD_W  = ffea_pkg::CMD_W;
  localparam int ADDR_W = ffea_pkg::ADDR_W;
  localparam int ID_W   = ffea_pkg::ID_W;
  localparam int EIDX_W = ffea_pkg::EIDX_W;
  localparam int SUM_W  = ffea_pkg::SUM_W;
  // Drain time at the end, sized from the table depth to cover the longest command.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  // Scoreboard: keeps its own copy of the extent table and of disk_size,
  // predicts one result per accepted command, and checks results in order.
  class extent_scoreboard;
    logic [ADDR_W-1:0] disk_size;
    logic [ADDR_W-1:0] ext_start [DEPTH];
    logic [ADDR_W-1:0] ext_size [DEPTH];
    logic [ID_W-1:0]   ext_id [DEPTH];
    int                count;
    ffea_pkg::out_t    expected_q [$];
    int                errors;

    function new();
      disk_size = '0;
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // First-fit search from address 1; all sums are kept wide, no wrap.
    function logic [ADDR_W-1:0] first_fit(logic [ADDR_W-1:0] want);
      logic [SUM_W-1:0] a;
      int k;
      a = SUM_W'(1);
      k = 0;
      while (a + SUM_W'(want) < SUM_W'(disk_size)) begin
        if (k >= count) return ADDR_W'(a);
        if (a < SUM_W'(ext_start[k])) begin
          if (a + SUM_W'(want) < SUM_W'(ext_start[k])) return ADDR_W'(a);
          a = SUM_W'(ext_start[k]) + SUM_W'(ext_size[k]) + SUM_W'(1);
        end
        k++;
      end
      return '0;
    endfunction

    function void note_command(ffea_pkg::in_t cmd);
      ffea_pkg::out_t exp;
      int pos, k;
      bit hit;
      exp = '0;
      case (cmd.command)
        ffea_pkg::CMD_FIND: begin
          exp.found_addr = first_fit(cmd.req_size);
          exp.status = (exp.found_addr == '0) ? ffea_pkg::ST_NO_SPACE : ffea_pkg::ST_OK;
        end
        ffea_pkg::CMD_ALLOC: begin
          if (count >= DEPTH) begin
            exp.status = ffea_pkg::ST_FULL;
          end else if (SUM_W'(cmd.start_addr) + SUM_W'(cmd.req_size) >= SUM_W'(disk_size)) begin
            exp.status = ffea_pkg::ST_NO_SPACE;
          end else begin
            // equal starts: new extent goes after the existing ones
            pos = 0;
            while (pos < count && ext_start[pos] <= cmd.start_addr) pos++;
            for (k = count; k > pos; k--) begin
              ext_start[k] = ext_start[k-1];
              ext_size[k]  = ext_size[k-1];
              ext_id[k]    = ext_id[k-1];
            end
            ext_start[pos] = cmd.start_addr;
            ext_size[pos]  = cmd.req_size;
            ext_id[pos]    = cmd.file_id;
            count++;
          end
        end
        ffea_pkg::CMD_RELEASE: begin
          pos = 0;
          while (pos < count && ext_id[pos] != cmd.file_id) pos++;
          if (pos >= count) begin
            exp.status = ffea_pkg::ST_NOT_FOUND;
          end else begin
            for (k = pos + 1; k < count; k++) begin
              ext_start[k-1] = ext_start[k];
              ext_size[k-1]  = ext_size[k];
              ext_id[k-1]    = ext_id[k];
            end
            count--;
          end
        end
        default: begin
          // touching neighbors count as an overlap
          exp.error_index = EIDX_W'(count);
          hit = 1'b0;
          for (k = 1; k < count; k++) begin
            if (!hit && SUM_W'(ext_start[k-1]) + SUM_W'(ext_size[k-1])
                        >= SUM_W'(ext_start[k])) begin
              exp.error_index = EIDX_W'(k - 1);
              hit = 1'b1;
            end
          end
        end
      endcase
      expected_q.push_back(exp);
    endfunction

    function void check_result(ffea_pkg::out_t got);
      ffea_pkg::out_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d found_addr %0h error_index %0d",
               got.status, got.found_addr, got.error_index);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.found_addr !== exp.found_addr) begin
        $error("found_addr: expected %0h, actual %0h", exp.found_addr, got.found_addr);
        errors++;
      end
      if (got.error_index !== exp.error_index) begin
        $error("error_index: expected %0d, actual %0d", exp.error_index, got.error_index);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  ffea_pkg::in_t     in_data = '0;
  logic              busy;
  logic              out_valid;
  ffea_pkg::out_t    out_data;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  extent_scoreboard alloc_model = new();

  // 12 ns period
  always #6 clk = ~clk;

  first_fit_extent_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Monitor: everything is sampled at the rising edge. The result of the
  // previous transaction is checked before a new command is noted, in case
  // both land on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) alloc_model.check_result(out_data);
      if (start && !busy) alloc_model.note_command(in_data);
    end
  end

  // Random command, built from the scoreboard's current table so that most
  // allocations and releases do something: ids come from a small pool,
  // releases mostly name a live id, and some allocations land on the
  // first-fit hole or exactly at the disk boundary. A few are pure noise.
  function automatic ffea_pkg::in_t random_command();
    ffea_pkg::in_t c;
    logic [ADDR_W-1:0] d, hi, room;
    int r, pick;
    d = alloc_model.disk_size;
    hi = (d > 32'd16) ? (d >> 4) : 32'd3;
    c.command    = ffea_pkg::CMD_FIND;
    c.start_addr = $urandom;
    c.req_size   = $urandom;
    c.file_id    = ID_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      c.command = CMD_W'($urandom_range(0, 3));
      return c;
    end
    if ($urandom_range(0, 7) != 0) c.file_id = ID_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) c.req_size = $urandom_range(0, hi);
    if (d != '0) c.start_addr = $urandom_range(0, d - 1);
    if (r < 45) begin
      c.command = ffea_pkg::CMD_ALLOC;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        c.start_addr = alloc_model.first_fit(c.req_size);
      end else if (pick == 3 && c.start_addr < d) begin
        // end exactly at the disk size (rejected) or one below it (accepted)
        room = d - c.start_addr;
        c.req_size = room - $urandom_range(0, 1);
      end
    end else if (r < 70) begin
      c.command = ffea_pkg::CMD_RELEASE;
      if (alloc_model.count > 0 && $urandom_range(0, 3) != 0)
        c.file_id = alloc_model.ext_id[$urandom_range(0, alloc_model.count - 1)];
    end else if (r < 88) begin
      c.command = ffea_pkg::CMD_FIND;
    end else begin
      c.command = ffea_pkg::CMD_CHECK;
    end
    return c;
  endfunction

  // Present one command at the falling edge and hold it until a rising edge
  // sees busy low. Random commands are built only after the falling edge so
  // the scoreboard has already noted the previous transaction.
  task automatic send_command(ffea_pkg::in_t cmd, bit pick_random);
    @(negedge clk);
    if (pick_random) cmd = random_command();
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and keep it low for a pause whose length is set by n.
  task automatic pause_sender(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop issuing and wait until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (alloc_model.pending() > 0 || busy) @(posedge clk);
  endtask

  // disk_size is only written while the block is idle.
  task automatic write_disk(logic [ADDR_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    alloc_model.disk_size = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      send_command('0, 1'b1);
      if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 16));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] plan [8];
    plan = '{32'd1000, 32'd2, 32'hFFFF_FFFF, 32'd64, 32'd0, 32'd0, 32'd50000,
             32'hFFFF_FFFF};
    plan[4] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero-size disk after reset: nothing fits, nothing to release.
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_FIND,    32'd0, 32'd0, 16'd0}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC,   32'd0, 32'd0, 16'd0}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_RELEASE, 32'd0, 32'd0, 16'd5}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_CHECK,   32'd0, 32'd0, 16'd0}, 1'b0);

    // Full-range disk.
    write_disk(32'hFFFF_FFFF);
    // empty table
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_CHECK, 32'd0, 32'd0, 16'd0}, 1'b0);
    // hits address 1
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_FIND,  32'd0, 32'd0, 16'd0}, 1'b0);
    // ends one below
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'hFFFF_FFF0, 32'hE, 16'hFFFF}, 1'b0);
    // sum would wrap in 32 bits; must be rejected
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd7},
                 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'd100, 32'd50, 16'd1}, 1'b0);
    // equal start
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'd100, 32'd10, 16'd2}, 1'b0);
    // overlap at 0
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_CHECK, 32'd0, 32'd0, 16'd0}, 1'b0);
    // skips past both
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_FIND,  32'd0, 32'd99, 16'd0}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_RELEASE, 32'd0, 32'd0, 16'd1}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_CHECK, 32'd0, 32'd0, 16'd0}, 1'b0);
    // no such id
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_RELEASE, 32'd0, 32'd0, 16'h1234}, 1'b0);
    // nothing fits
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_FIND,  32'd0, 32'hFFFF_FFFF, 16'd0}, 1'b0);
    // zero-size at 0
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'd0, 32'd0, 16'd0}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_CHECK, 32'd0, 32'd0, 16'd0}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_RELEASE, 32'd0, 32'd0, 16'd0}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'd200, 32'd5, 16'd3}, 1'b0);
    // touches previous
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_ALLOC, 32'd205, 32'd1, 16'd4}, 1'b0);
    send_command(ffea_pkg::in_t'{ffea_pkg::CMD_CHECK, 32'd0, 32'd0, 16'd0}, 1'b0);

    // Random phases; the table carries over from one disk size to the next.
    foreach (plan[p]) begin
      write_disk(plan[p]);
      run_random(215, $urandom_range(0, 2) * 20);
    end

    // Final stretch without sender gaps.
    write_disk(32'd4096);
    run_random(130, 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alloc_model.errors == 0 && alloc_model.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ffea_pkg.sv
hdl/ffea_alu.sv
hdl/ffea_ctrl.sv
hdl/first_fit_extent_allocator.sv
bench/first_fit_extent_allocator_tb.sv
